FILE: hw/rtl/rpwc_pkg.sv
package rpwc_pkg;

  localparam int unsigned CH_W       = 3;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned OFS_W      = 11;
  localparam int unsigned SCALED_W   = 20;
  localparam int unsigned ANGLE_W    = 7;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PURPOSE_MAP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE   = CFG_IDX_W'(1);

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Pulse width limits in ticks
  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(999);
  localparam logic [WIDTH_W-1:0] WIDTH_BASE  = WIDTH_W'(1000);
  localparam logic [WIDTH_W-1:0] OFS_MAX     = WIDTH_W'(1100);
  localparam logic [OFS_W-1:0]   SW_LOW      = OFS_W'(250);
  localparam logic [OFS_W-1:0]   SW_HIGH     = OFS_W'(750);
  localparam logic [OFS_W:0]     ANGLE_MID   = (OFS_W + 1)'(500);
  localparam logic [16:0]        DEADBAND    = 17'd1000;
  localparam logic [6:0]         DIV_CONST   = 7'd125;
  // floor(2^30 / 125), reciprocal used for the divide by 125
  localparam logic [23:0]        RECIP_125   = 24'd8589934;
  localparam int unsigned        RECIP_SHIFT = 30;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = '1;
  localparam logic [ANGLE_W-1:0] ANGLE_RESET = ANGLE_W'(30);

  typedef enum logic [1:0] {
    PURP_KNOB    = 2'd0,
    PURP_SWITCH  = 2'd1,
    PURP_ANGLE   = 2'd2,
    PURP_INVALID = 2'd3
  } purpose_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_RECIP,
    ST_FIX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic edge_en;
    logic start;
    logic load;
    logic mul;
    logic recip;
    logic fix;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic last_ch;
  } sts_t;

endpackage

FILE: hw/rtl/rpwc_ctrl.sv
module rpwc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          req_type_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rpwc_pkg::cmd_t cmd_o,
  input  rpwc_pkg::sts_t sts_i
);

  rpwc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      rpwc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (req_type_i == rpwc_pkg::REQ_READ) begin
            cmd_o.start = 1'b1;
            state_d     = rpwc_pkg::ST_LOAD;
          end else begin
            cmd_o.edge_en = 1'b1;
          end
        end
      end
      rpwc_pkg::ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = rpwc_pkg::ST_MUL;
      end
      rpwc_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = rpwc_pkg::ST_RECIP;
      end
      rpwc_pkg::ST_RECIP: begin
        cmd_o.recip = 1'b1;
        state_d     = rpwc_pkg::ST_FIX;
      end
      rpwc_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = rpwc_pkg::ST_OUT;
      end
      rpwc_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.last_ch) begin
            state_d = rpwc_pkg::ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = rpwc_pkg::ST_LOAD;
          end
        end
      end
      default: state_d = rpwc_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/rpwc_datapath.sv
module rpwc_datapath #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rpwc_pkg::cmd_t                      cmd_i,
  output rpwc_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [rpwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rpwc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [rpwc_pkg::CH_W-1:0]           channel_i,
  input  logic                                level_i,
  input  logic [rpwc_pkg::TS_W-1:0]           timestamp_i,
  output logic [rpwc_pkg::CH_W-1:0]           out_channel_o,
  output logic [rpwc_pkg::OFS_W-1:0]          offset_width_o,
  output logic signed [rpwc_pkg::SCALED_W-1:0] scaled_q8_o,
  output logic                                range_error_o,
  output logic                                purpose_error_o,
  output logic                                last_o
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [rpwc_pkg::CH_W:0] NUM_CH = (rpwc_pkg::CH_W + 1)'(NUM_CHANNELS);
  localparam logic [rpwc_pkg::CH_W-1:0] LAST_CH = rpwc_pkg::CH_W'(NUM_CHANNELS - 1);

  // Configuration registers
  logic [rpwc_pkg::CFG_DATA_W-1:0] purpose_map_q;
  logic [rpwc_pkg::ANGLE_W-1:0]    full_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      purpose_map_q <= '0;
      full_scale_q  <= rpwc_pkg::ANGLE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rpwc_pkg::CFG_PURPOSE_MAP: purpose_map_q <= cfg_data_i;
        rpwc_pkg::CFG_MAX_ANGLE:   full_scale_q  <= cfg_data_i[rpwc_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel capture state
  logic [rpwc_pkg::TS_W-1:0]    rise_q  [NUM_CHANNELS];
  logic [rpwc_pkg::WIDTH_W-1:0] width_q [NUM_CHANNELS];
  logic                         ch_ok;
  logic [rpwc_pkg::TS_W-1:0]    edge_w;
  logic [rpwc_pkg::WIDTH_W-1:0] edge_sat;

  assign ch_ok    = {1'b0, channel_i} < NUM_CH;
  assign edge_w   = timestamp_i - rise_q[channel_i[IDX_W-1:0]];
  assign edge_sat = (|edge_w[rpwc_pkg::TS_W-1:rpwc_pkg::WIDTH_W]) ?
                    rpwc_pkg::WIDTH_RESET : edge_w[rpwc_pkg::WIDTH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        rise_q[i]  <= '0;
        width_q[i] <= rpwc_pkg::WIDTH_RESET;
      end
    end else if (cmd_i.edge_en && ch_ok) begin
      if (level_i) begin
        rise_q[channel_i[IDX_W-1:0]] <= timestamp_i;
      end else begin
        width_q[channel_i[IDX_W-1:0]] <= edge_sat;
      end
    end
  end

  // Read walk counter
  logic [rpwc_pkg::CH_W-1:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.start) begin
      idx_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign sts_o.last_ch = (idx_q == LAST_CH);

  // Load: offset, range check, purpose
  logic [rpwc_pkg::WIDTH_W-1:0] ld_w;
  logic [rpwc_pkg::WIDTH_W-1:0] ld_ofs;
  logic                         ld_rerr;
  logic [rpwc_pkg::OFS_W-1:0]   ofs_q;
  logic                         rerr_q;
  logic [1:0]                   purpose_q;

  assign ld_w    = width_q[idx_q[IDX_W-1:0]];
  assign ld_ofs  = (ld_w <= rpwc_pkg::WIDTH_MIN) ? '0 : (ld_w - rpwc_pkg::WIDTH_BASE);
  assign ld_rerr = ld_ofs > rpwc_pkg::OFS_MAX;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ofs_q     <= ld_rerr ? '0 : ld_ofs[rpwc_pkg::OFS_W-1:0];
      rerr_q    <= ld_rerr;
      purpose_q <= purpose_map_q[{idx_q, 1'b0} +: 2];
    end
  end

  // Angle: p = full-scale angle * (ofs - 500)
  logic signed [rpwc_pkg::OFS_W:0]  dev;
  logic signed [rpwc_pkg::OFS_W+8:0] p_d;
  logic signed [rpwc_pkg::OFS_W+8:0] p_q;

  assign dev = $signed({1'b0, ofs_q}) - $signed(rpwc_pkg::ANGLE_MID);
  assign p_d = dev * $signed({1'b0, full_scale_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_q <= p_d;
    end
  end

  // Round(64*|p|/125) = floor((64*|p| + 62) / 125), via reciprocal
  logic [16:0] mag;
  logic [22:0] y_d;
  logic [46:0] prod;
  logic [22:0] y_q;
  logic [15:0] est_q;
  logic        neg_q;
  logic        dead_q;

  assign mag  = p_q[rpwc_pkg::OFS_W+8] ? 17'(-p_q) : 17'(p_q);
  assign y_d  = {mag, 6'd0} + 23'd62;
  assign prod = y_d * rpwc_pkg::RECIP_125;

  always_ff @(posedge clk_i) begin
    if (cmd_i.recip) begin
      y_q    <= y_d;
      est_q  <= prod[rpwc_pkg::RECIP_SHIFT +: 16];
      neg_q  <= p_q[rpwc_pkg::OFS_W+8];
      dead_q <= mag < rpwc_pkg::DEADBAND;
    end
  end

  // Fix: estimate is low by at most one
  logic [22:0] rem;
  logic [16:0] quo;
  logic signed [rpwc_pkg::SCALED_W-1:0] angle_val;
  logic signed [rpwc_pkg::SCALED_W-1:0] scaled_d;

  assign rem       = y_q - (23'(est_q) * 23'(rpwc_pkg::DIV_CONST));
  assign quo       = (rem >= 23'(rpwc_pkg::DIV_CONST)) ? ({1'b0, est_q} + 17'd1) : {1'b0, est_q};
  assign angle_val = dead_q ? '0 :
                     (neg_q ? -$signed(rpwc_pkg::SCALED_W'(quo))
                            :  $signed(rpwc_pkg::SCALED_W'(quo)));

  always_comb begin
    unique case (rpwc_pkg::purpose_e'(purpose_q))
      rpwc_pkg::PURP_KNOB:   scaled_d = $signed(rpwc_pkg::SCALED_W'({ofs_q, 8'd0}));
      rpwc_pkg::PURP_SWITCH: begin
        if (ofs_q > rpwc_pkg::SW_HIGH) begin
          scaled_d = rpwc_pkg::SCALED_W'(768);
        end else if (ofs_q > rpwc_pkg::SW_LOW) begin
          scaled_d = rpwc_pkg::SCALED_W'(512);
        end else begin
          scaled_d = rpwc_pkg::SCALED_W'(256);
        end
      end
      rpwc_pkg::PURP_ANGLE:  scaled_d = angle_val;
      default:               scaled_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fix) begin
      out_channel_o   <= idx_q;
      offset_width_o  <= ofs_q;
      scaled_q8_o     <= scaled_d;
      range_error_o   <= rerr_q;
      purpose_error_o <= (purpose_q == rpwc_pkg::PURP_INVALID);
      last_o          <= (idx_q == LAST_CH);
    end
  end

endmodule

FILE: hw/rtl/rc_pulse_width_capture.sv
// Multi-channel RC pulse width capture.
//
// Input channel (in_valid_i / in_stall_o): one transfer is either an edge
// event (req_type_i = 0) or a read request (req_type_i = 1). An edge event
// is absorbed in the cycle of its transfer and gives no result; a rising
// level stores the channel's timestamp, a falling level stores the width.
// Edges on channels at or above NUM_CHANNELS are dropped.
// A read request emits NUM_CHANNELS results on the output channel
// (out_valid_o / out_stall_i), channel 0 first, last_o set on the final one.
// Each result passes through load, multiply by the full-scale angle,
// reciprocal multiply (the angle path's divide by 125), rounding fix and
// present, in that order; in_stall_o stays high until the last result
// transfers. An output stall holds the current result and the walk.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready: index 0 writes
// purpose_map, index 1 the full-scale angle, other indexes are dropped.
// After reset all rise times are zero, all widths read as range errors,
// purpose_map is 0 and the full-scale angle is 30.
module rc_pulse_width_capture #(
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration port
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rpwc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rpwc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic [rpwc_pkg::CH_W-1:0]            channel_i,
  input  logic                                 level_i,
  input  logic [rpwc_pkg::TS_W-1:0]            timestamp_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rpwc_pkg::CH_W-1:0]            out_channel_o,
  output logic [rpwc_pkg::OFS_W-1:0]           offset_width_o,
  output logic signed [rpwc_pkg::SCALED_W-1:0] scaled_q8_o,
  output logic                                 range_error_o,
  output logic                                 purpose_error_o,
  output logic                                 last_o
);

  rpwc_pkg::cmd_t cmd;
  rpwc_pkg::sts_t sts;

  // Registers take a write in any cycle; software writes only while idle.
  assign cfg_ready_o = 1'b1;

  rpwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rpwc_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .channel_i       (channel_i),
    .level_i         (level_i),
    .timestamp_i     (timestamp_i),
    .out_channel_o   (out_channel_o),
    .offset_width_o  (offset_width_o),
    .scaled_q8_o     (scaled_q8_o),
    .range_error_o   (range_error_o),
    .purpose_error_o (purpose_error_o),
    .last_o          (last_o)
  );

endmodule

FILE: tb/tb_rc_pulse_width_capture.sv
`timescale 1ns / 100ps

module tb_rc_pulse_width_capture;
  import rpwc_pkg::*;

  localparam int unsigned NUM_CH       = 6;
  // Edge transfers give no result; allow the block this many cycles to settle
  // before a register write or the end of the run.
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  // One result of a read request, as the block should present it
  typedef struct {
    logic [CH_W-1:0]            ch;
    logic [OFS_W-1:0]           ofs;
    logic signed [SCALED_W-1:0] scaled;
    logic                       rerr;
    logic                       perr;
    logic                       last;
  } chan_result_t;

  typedef enum logic [1:0] {
    ROW_EDGE,
    ROW_READ,
    ROW_WRITE
  } row_kind_e;

  // One line of the directed table. A read row may carry a typed-in
  // expectation that holds for every channel.
  typedef struct {
    row_kind_e                  kind;
    logic [CH_W-1:0]            ch;
    logic                       lvl;
    logic [TS_W-1:0]            ts;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_DATA_W-1:0]      data;
    bit                         typed;
    logic [OFS_W-1:0]           t_ofs;
    logic signed [SCALED_W-1:0] t_scaled;
    logic                       t_rerr;
    logic                       t_perr;
  } dir_row_t;

  // Clock, reset and every block input start at a known value
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic            req_type_i  = REQ_EDGE;
  logic [CH_W-1:0] channel_i   = '0;
  logic            level_i     = 1'b0;
  logic [TS_W-1:0] timestamp_i = '0;

  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [CH_W-1:0]            out_channel_o;
  logic [OFS_W-1:0]           offset_width_o;
  logic signed [SCALED_W-1:0] scaled_q8_o;
  logic                       range_error_o;
  logic                       purpose_error_o;
  logic                       last_o;

  // Shadow of the block's state and registers
  logic [TS_W-1:0]       rise_q  [NUM_CH];
  logic [WIDTH_W-1:0]    width_q [NUM_CH];
  logic [CFG_DATA_W-1:0] purpose_q = '0;
  logic [ANGLE_W-1:0]    angle_q   = 7'd30;

  chan_result_t pending_results[$];
  dir_row_t     dir_rows[$];

  bit          no_gaps    = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned n_edges    = 0;
  int unsigned n_reads    = 0;
  int unsigned n_checked  = 0;
  int unsigned n_writes   = 0;

  rc_pulse_width_capture #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .channel_i      (channel_i),
    .level_i        (level_i),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_channel_o  (out_channel_o),
    .offset_width_o (offset_width_o),
    .scaled_q8_o    (scaled_q8_o),
    .range_error_o  (range_error_o),
    .purpose_error_o(purpose_error_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then a long one.
  // Drop all idling while a burst phase is running.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pulse width for a rise/fall pair: mostly inside the legal band, with
  // weight on the band edges, the switch thresholds and the angle deadband.
  function automatic logic [TS_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1000, 2100);
    if (r < 75) begin
      case ($urandom_range(0, 12))
        0:       return 999;
        1:       return 1000;
        2:       return 1001;
        3:       return 1250;
        4:       return 1251;
        5:       return 1750;
        6:       return 1751;
        7:       return 1466;
        8:       return 1467;
        9:       return 1533;
        10:      return 1534;
        11:      return 2100;
        default: return 2101;
      endcase
    end
    if (r < 85) return $urandom_range(0, 999);
    if (r < 95) return $urandom_range(2101, 65535);
    // Anything at all: saturates, and exercises the modulo wrap
    return $urandom;
  endfunction

  // Purpose scaling of one offset width into signed Q8
  function automatic logic signed [SCALED_W-1:0] scale_for(purpose_e purp, int unsigned ov);
    longint m;
    longint num;
    longint v;
    m = angle_q;
    case (purp)
      PURP_KNOB:   v = longint'(ov) * 256;
      PURP_SWITCH: v = (ov > 750) ? 768 : ((ov > 250) ? 512 : 256);
      PURP_ANGLE: begin
        // Exact angle times 256000; round to 1/256, ties away from zero
        num = longint'(ov) * 512 * m - m * 256000;
        if (num < 512000 && num > -512000)
          v = 0;
        else if (num >= 0)
          v = (num + 500) / 1000;
        else
          v = -((-num + 500) / 1000);
      end
      default:     v = 0;
    endcase
    return v[SCALED_W-1:0];
  endfunction

  // Edge transfer: store a rise time, or a saturated width on a fall
  function automatic void capture_edge(logic [CH_W-1:0] ch, logic lvl, logic [TS_W-1:0] ts);
    logic [TS_W-1:0] w;
    if (ch >= NUM_CH) return;
    n_edges++;
    if (lvl) begin
      rise_q[ch] = ts;
    end else begin
      w = ts - rise_q[ch];
      width_q[ch] = (w > 32'hFFFF) ? 16'hFFFF : w[WIDTH_W-1:0];
    end
  endfunction

  // Read transfer: queue one expected result per channel
  function automatic void decode_widths();
    chan_result_t r;
    int unsigned  ov;
    logic [1:0]   purp;
    for (int i = 0; i < NUM_CH; i++) begin
      ov     = (width_q[i] <= 999) ? 0 : width_q[i] - 1000;
      r.rerr = (ov > 1100);
      if (r.rerr) ov = 0;
      purp     = purpose_q[2*i +: 2];
      r.ch     = i[CH_W-1:0];
      r.ofs    = ov[OFS_W-1:0];
      r.scaled = scale_for(purpose_e'(purp), ov);
      r.perr   = (purpose_e'(purp) == PURP_INVALID);
      r.last   = (i == NUM_CH - 1);
      pending_results.push_back(r);
    end
    n_reads++;
  endfunction

  function automatic dir_row_t edge_row(logic [CH_W-1:0] ch, logic lvl, logic [TS_W-1:0] ts);
    dir_row_t r;
    r.kind = ROW_EDGE;
    r.ch   = ch;
    r.lvl  = lvl;
    r.ts   = ts;
    return r;
  endfunction

  function automatic dir_row_t read_row(logic [CH_W-1:0] ch, logic lvl, logic [TS_W-1:0] ts);
    dir_row_t r;
    r.kind  = ROW_READ;
    r.ch    = ch;
    r.lvl   = lvl;
    r.ts    = ts;
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    dir_row_t r;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Offer one request after a random gap and hold it until the transfer.
  // Valid stays high on return so a back-to-back request keeps it up.
  task automatic send_item(logic req, logic [CH_W-1:0] ch, logic lvl, logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    channel_i   <= ch;
    level_i     <= lvl;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the sender until every expected result is out, then let the
  // block settle so a register write finds it idle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PURPOSE_MAP: purpose_q = data;
      CFG_MAX_ANGLE:   angle_q   = data[ANGLE_W-1:0];
      default: ;  // unknown index: the block drops the write
    endcase
    n_writes++;
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      fail_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Receiver: stall in random bursts, none at all during a burst phase
  always @(posedge clk_i) begin
    if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0)
      stall_left = pick_gap();
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    chan_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_cnt++;
        $display("%0t ns: result for channel %0d with nothing expected, expected none, got one",
                 $time, out_channel_o);
      end else begin
        e = pending_results.pop_front();
        check_field("out_channel",   e.ch,     out_channel_o);
        check_field("offset_width",  e.ofs,    offset_width_o);
        check_field("scaled_q8",     e.scaled, scaled_q8_o);
        check_field("range_error",   e.rerr,   range_error_o);
        check_field("purpose_error", e.perr,   purpose_error_o);
        check_field("last",          e.last,   last_o);
        n_checked++;
      end
    end
  end

  // Watchdog: end a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t     row;
    chan_result_t exp_r;
    int unsigned  pick;
    int unsigned  budget;
    logic [CH_W-1:0] ch_pick;
    logic [TS_W-1:0] ts0;
    logic [TS_W-1:0] w;

    for (int i = 0; i < NUM_CH; i++) begin
      rise_q[i]  = '0;
      width_q[i] = 16'hFFFF;
    end

    // Directed table. Widths land on the band limits, the modulo wrap, the
    // 16-bit saturation and channels beyond the last one.
    row        = read_row(3'd7, 1'b1, 32'hFFFF_FFFF);
    // After reset every width is all ones: each channel is a range error
    row.typed    = 1'b1;
    row.t_ofs    = '0;
    row.t_scaled = '0;
    row.t_rerr   = 1'b1;
    row.t_perr   = 1'b0;
    dir_rows.push_back(row);
    dir_rows.push_back(edge_row(3'd0, 1'b1, 32'hFFFF_FF00));
    dir_rows.push_back(edge_row(3'd0, 1'b0, 32'h0000_0200));  // wraps to 768
    dir_rows.push_back(edge_row(3'd1, 1'b1, 32'd100));
    dir_rows.push_back(edge_row(3'd1, 1'b0, 32'd1099));       // 999
    dir_rows.push_back(edge_row(3'd2, 1'b1, 32'd0));
    dir_rows.push_back(edge_row(3'd2, 1'b0, 32'd1000));       // exactly 1000
    dir_rows.push_back(edge_row(3'd3, 1'b1, 32'd0));
    dir_rows.push_back(edge_row(3'd3, 1'b0, 32'hFFFF_FFFF));  // saturates
    dir_rows.push_back(edge_row(3'd4, 1'b1, 32'd5000));
    dir_rows.push_back(edge_row(3'd4, 1'b0, 32'd7100));       // offset 1100
    dir_rows.push_back(edge_row(3'd5, 1'b1, 32'h8000_0000));
    dir_rows.push_back(edge_row(3'd5, 1'b0, 32'h8000_0835));  // offset 1101
    dir_rows.push_back(edge_row(3'd7, 1'b0, 32'hFFFF_FFFF));  // no such channel
    dir_rows.push_back(edge_row(3'd6, 1'b1, 32'h7FFF_FFFF));  // no such channel
    dir_rows.push_back(read_row(3'd0, 1'b0, 32'd0));
    // knob, switch, angle, invalid, angle, switch on channels 0..5
    dir_rows.push_back(write_row(CFG_PURPOSE_MAP, 16'h06E4));
    dir_rows.push_back(write_row(CFG_MAX_ANGLE, 16'd90));
    dir_rows.push_back(read_row(3'd5, 1'b1, 32'h1234_5678));
    dir_rows.push_back(edge_row(3'd1, 1'b1, 32'd0));
    dir_rows.push_back(edge_row(3'd1, 1'b0, 32'd1751));       // switch top
    dir_rows.push_back(edge_row(3'd2, 1'b0, 32'd1750));       // angle 45
    dir_rows.push_back(read_row(3'd2, 1'b0, 32'hA5A5_A5A5));
    dir_rows.push_back(write_row(CFG_MAX_ANGLE, 16'd0));
    dir_rows.push_back(read_row(3'd3, 1'b1, 32'd1));
    dir_rows.push_back(write_row(CFG_PURPOSE_MAP, 16'hFFFF));
    dir_rows.push_back(write_row(4'hF, 16'hFFFF));            // unknown index
    dir_rows.push_back(write_row(4'h2, 16'h0000));            // unknown index
    dir_rows.push_back(read_row(3'd4, 1'b0, 32'd0));
    dir_rows.push_back(write_row(CFG_MAX_ANGLE, 16'd127));    // above 90
    dir_rows.push_back(write_row(CFG_PURPOSE_MAP, 16'hAAAA));
    dir_rows.push_back(read_row(3'd1, 1'b1, 32'h5A5A_5A5A));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      case (row.kind)
        ROW_WRITE: begin
          drain_results();
          write_reg(row.idx, row.data);
        end
        ROW_EDGE: begin
          send_item(REQ_EDGE, row.ch, row.lvl, row.ts);
          capture_edge(row.ch, row.lvl, row.ts);
        end
        default: begin
          send_item(REQ_READ, row.ch, row.lvl, row.ts);
          if (row.typed) begin
            for (int c = 0; c < NUM_CH; c++) begin
              exp_r.ch     = c[CH_W-1:0];
              exp_r.ofs    = row.t_ofs;
              exp_r.scaled = row.t_scaled;
              exp_r.rerr   = row.t_rerr;
              exp_r.perr   = row.t_perr;
              exp_r.last   = (c == NUM_CH - 1);
              pending_results.push_back(exp_r);
            end
            n_reads++;
          end else begin
            decode_widths();
          end
        end
      endcase
    end

    // Random phases, one register setting each. Mostly well-formed
    // rise/fall pairs with random content, some reads, some stray edges.
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      no_gaps = (phase == 2);
      case (phase)
        0: begin
          write_reg(CFG_PURPOSE_MAP, 16'h0000);
          write_reg(CFG_MAX_ANGLE, 16'd30);
        end
        1: begin
          write_reg(CFG_PURPOSE_MAP, 16'hAAAA);
          write_reg(CFG_MAX_ANGLE, 16'd90);
        end
        2: begin
          write_reg(CFG_PURPOSE_MAP, 16'h5555);
          write_reg(CFG_MAX_ANGLE, 16'd0);
        end
        3: begin
          write_reg(CFG_PURPOSE_MAP, 16'($urandom));
          // Upper data bits carry junk; only the low seven take effect
          write_reg(CFG_MAX_ANGLE, (16'($urandom) & 16'hFF80) | 16'd127);
        end
        default: begin
          write_reg(CFG_PURPOSE_MAP, 16'($urandom));
          write_reg(CFG_MAX_ANGLE, 16'($urandom_range(0, 90)));
          write_reg(4'($urandom_range(2, 15)), 16'($urandom));
        end
      endcase

      budget = n_edges + n_reads + 67;
      while (n_edges + n_reads < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_item(REQ_READ, 3'($urandom), 1'($urandom), $urandom);
          decode_widths();
        end else if (pick < 25) begin
          // Stray edge: any channel, any level, any time
          ch_pick = 3'($urandom_range(0, 7));
          w       = $urandom;
          pick    = $urandom_range(0, 1);
          send_item(REQ_EDGE, ch_pick, pick[0], w);
          capture_edge(ch_pick, pick[0], w);
        end else begin
          ch_pick = 3'($urandom_range(0, NUM_CH - 1));
          ts0     = $urandom;
          w       = pick_width();
          send_item(REQ_EDGE, ch_pick, 1'b1, ts0);
          capture_edge(ch_pick, 1'b1, ts0);
          send_item(REQ_EDGE, ch_pick, 1'b0, ts0 + w);
          capture_edge(ch_pick, 1'b0, ts0 + w);
        end
      end
    end

    no_gaps = 1'b0;
    drain_results();
    repeat (20) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      fail_cnt++;
      $display("%0t ns: results left over, expected 0, got %0d", $time, pending_results.size());
    end

    $display("Checked %0d results from %0d read requests and %0d accepted edge transfers",
             n_checked, n_reads, n_edges);
    $display("Register writes: %0d, across knob, switch, angle and invalid mappings", n_writes);
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
